[src/delta_varint_posting_encoder_assert.svh]
// Assertion macros for the posting encoder.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef DELTA_VARINT_POSTING_ENCODER_ASSERT_SVH
`define DELTA_VARINT_POSTING_ENCODER_ASSERT_SVH

// same-cycle implication
`define DVPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dvpe assertion failed");

// next-cycle implication
`define DVPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dvpe assertion failed");

`endif

[src/dvpe_pkg.sv]
// Shared types and constants for the delta/varint posting encoder.
// No dependencies.
package dvpe_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [WordW-1:0] TotalMax = {WordW{1'b1}};

  typedef enum logic {
    MODE_DOC = 1'b0,
    MODE_POS = 1'b1
  } mode_e;

  // one queued item: one or two numbers to be varint coded
  typedef struct packed {
    logic [WordW-1:0] num_a;
    logic [WordW-1:0] num_b;
    logic             two_nums;
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

endpackage

[src/dvpe_front.sv]
// Front end: accepts posting items, forms document and position gaps.
// Depends on dvpe_pkg.
module dvpe_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [dvpe_pkg::WordW-1:0] doc_id_i,
  input  logic [dvpe_pkg::WordW-1:0] position_count_i,
  input  logic [dvpe_pkg::WordW-1:0] word_position_i,
  input  logic                       first_of_term_i,
  input  dvpe_pkg::fifo_stat_t       stat_i,
  output logic                       push_o,
  output dvpe_pkg::entry_t           entry_o
);
  import dvpe_pkg::*;

  logic [WordW-1:0] prev_doc_q, prev_doc_d;
  logic [WordW-1:0] prev_pos_q, prev_pos_d;
  logic [WordW-1:0] base_doc;

  assign in_ready_o = !stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  // term flag clears the previous document before the gap is taken
  assign base_doc = first_of_term_i ? '0 : prev_doc_q;

  always_comb begin
    prev_doc_d = prev_doc_q;
    prev_pos_d = prev_pos_q;
    if (mode_i == MODE_DOC) begin
      entry_o.num_a    = doc_id_i - base_doc;
      entry_o.num_b    = position_count_i;
      entry_o.two_nums = 1'b1;
    end else begin
      entry_o.num_a    = word_position_i - prev_pos_q;
      entry_o.num_b    = '0;
      entry_o.two_nums = 1'b0;
    end
    if (push_o) begin
      if (mode_i == MODE_DOC) begin
        prev_doc_d = doc_id_i;
        prev_pos_d = '0;
      end else begin
        prev_doc_d = base_doc;
        prev_pos_d = word_position_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_doc_q <= '0;
      prev_pos_q <= '0;
    end else begin
      prev_doc_q <= prev_doc_d;
      prev_pos_q <= prev_pos_d;
    end
  end

endmodule

[src/dvpe_fifo.sv]
// Short queue between front and back ends.
// Depends on dvpe_pkg.
module dvpe_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dvpe_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output dvpe_pkg::entry_t     entry_o,
  output dvpe_pkg::fifo_stat_t stat_o
);
  import dvpe_pkg::*;

  entry_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  function automatic logic [FifoPtrW-1:0] ptr_inc(input logic [FifoPtrW-1:0] p);
    logic [FifoPtrW-1:0] r;
    if (p == FifoPtrW'(FifoDepth - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign entry_o      = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == FifoCntW'(FifoDepth));

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[src/dvpe_back.sv]
// Back end: splits queued numbers into base-128 groups, one word a cycle unless the output stalls,
// and keeps the saturating byte total. Depends on dvpe_pkg and the assert macros.
`include "delta_varint_posting_encoder_assert.svh"

module dvpe_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dvpe_pkg::fifo_stat_t       stat_i,
  input  dvpe_pkg::entry_t           entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dvpe_pkg::ByteW-1:0] code_byte_o,
  output logic                       last_of_item_o,
  output logic [dvpe_pkg::WordW-1:0] total_bytes_o
);
  import dvpe_pkg::*;

  logic [WordW-1:0] cur_q, cur_d;
  logic [WordW-1:0] second_q, second_d;
  logic             has_second_q, has_second_d;
  logic             active_q, active_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] code_q, code_d;
  logic             last_q, last_d;
  logic [WordW-1:0] total_q, total_d;

  logic more, final_byte, advance, emit, load;

  assign more       = (cur_q[WordW-1:GroupBits] != '0);
  assign final_byte = !more && !has_second_q;
  assign advance    = !out_valid_q || out_ready_i;
  assign emit       = active_q && advance;
  // next item loads while the last word of this one goes out
  assign load       = stat_i.valid && (!active_q || (emit && final_byte));
  assign pop_o      = load;

  always_comb begin
    cur_d        = cur_q;
    second_d     = second_q;
    has_second_d = has_second_q;
    active_d     = active_q;
    out_valid_d  = out_valid_q;
    code_d       = code_q;
    last_d       = last_q;
    total_d      = total_q;

    if (emit) begin
      out_valid_d = 1'b1;
      code_d      = {more, cur_q[GroupBits-1:0]};
      last_d      = final_byte;
      if (total_q != TotalMax) total_d = total_q + 1'b1;
      if (more) begin
        cur_d = cur_q >> GroupBits;
      end else if (has_second_q) begin
        cur_d        = second_q;
        has_second_d = 1'b0;
      end else begin
        active_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      cur_d        = entry_i.num_a;
      second_d     = entry_i.num_b;
      has_second_d = entry_i.two_nums;
      active_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    second_q <= second_d;
    code_q   <= code_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_second_q <= 1'b0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      total_q      <= '0;
    end else begin
      has_second_q <= has_second_d;
      active_q     <= active_d;
      out_valid_q  <= out_valid_d;
      total_q      <= total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_byte_o    = code_q;
  assign last_of_item_o = last_q;
  assign total_bytes_o  = total_q;

  `DVPE_ASSERT_IMP(a_cont_not_last, out_valid_q && code_q[ByteW-1], !last_q)
  `DVPE_ASSERT_NXT(a_emit_shows, emit, out_valid_q)
  `DVPE_ASSERT_NXT(a_total_step, emit && (total_q != TotalMax),
                   total_q == $past(total_q) + 1'b1)

endmodule

[src/delta_varint_posting_encoder.sv]
// Delta-gap varint posting encoder, top level: front end, queue, back end.
// Throughput: one output word per cycle while out_ready_i is not held low; an item has
// 1 to 5 words for a position and 2 to 10 for a document, made by the back-end serialiser.
// Reset: asynchronous, active low; clears previous ids, byte total and queue.
module delta_varint_posting_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [dvpe_pkg::WordW-1:0] doc_id_i,
  input  logic [dvpe_pkg::WordW-1:0] position_count_i,
  input  logic [dvpe_pkg::WordW-1:0] word_position_i,
  input  logic                       first_of_term_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dvpe_pkg::ByteW-1:0] code_byte_o,
  output logic                       last_of_item_o,
  output logic [dvpe_pkg::WordW-1:0] total_bytes_o
);
  import dvpe_pkg::*;

  fifo_stat_t stat;
  entry_t     push_entry, head_entry;
  logic       push, pop;

  dvpe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .doc_id_i         (doc_id_i),
    .position_count_i (position_count_i),
    .word_position_i  (word_position_i),
    .first_of_term_i  (first_of_term_i),
    .stat_i           (stat),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  dvpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (stat)
  );

  dvpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stat_i         (stat),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_byte_o    (code_byte_o),
    .last_of_item_o (last_of_item_o),
    .total_bytes_o  (total_bytes_o)
  );

endmodule
